@@ rtl/plsi_pkg.sv @@
// Package with the beat types, register codes and lattice tables of the site index block.
package plsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int SITE_BITS  = 26;
  localparam int OUT_BITS   = 9;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIDE_A = 2'd1;
  localparam logic [1:0] REG_SIDE_B = 2'd2;
  localparam logic [1:0] REG_SIDE_C = 2'd3;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_PARITY = 2'd1;
  localparam logic [1:0] FAULT_RANGE  = 2'd2;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_BITS-1:0]  x_coord;
    logic signed [COORD_BITS-1:0]  y_coord;
    logic signed [COORD_BITS-1:0]  z_coord;
    logic [SITE_BITS-1:0]          site_in;
  } in_beat_t;

  typedef struct packed {
    logic [SITE_BITS-1:0] site_out;
    logic [OUT_BITS-1:0]  x_out;
    logic [OUT_BITS-1:0]  y_out;
    logic [OUT_BITS-1:0]  z_out;
    logic [1:0]           fault;
  } out_beat_t;

  // Parity pattern is {z, y, x}.
  function automatic logic fcc_valid(input logic [2:0] pat);
    logic v;
    case (pat)
      3'd0, 3'd3, 3'd5, 3'd6: v = 1'b1;
      default:                v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] fcc_offset(input logic [2:0] pat);
    logic [1:0] o;
    case (pat)
      3'd3:    o = 2'd3;
      3'd5:    o = 2'd2;
      3'd6:    o = 2'd1;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

  // Returns parity bits {x, y, z} for a sublattice offset.
  function automatic logic [2:0] fcc_parity(input logic [1:0] off);
    logic [2:0] p;
    case (off)
      2'd1:    p = 3'b011;
      2'd2:    p = 3'b101;
      2'd3:    p = 3'b110;
      default: p = 3'b000;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/plsi_div_cell.sv @@
// One restoring division step for several lanes, with sideband carried along.
module plsi_div_cell #(
  parameter int DW    = 26,
  parameter int VW    = 10,
  parameter int LANES = 3,
  parameter int SBW   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic [LANES-1:0][DW-1:0]   dvd_i,
  input  logic [LANES-1:0][VW-1:0]   rem_i,
  input  logic [LANES-1:0][VW-1:0]   d_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       v_o,
  output logic [LANES-1:0][DW-1:0]   dvd_o,
  output logic [LANES-1:0][VW-1:0]   rem_o,
  output logic [LANES-1:0][VW-1:0]   d_o,
  output logic [SBW-1:0]             sb_o
);

  logic                     v_r;
  logic [LANES-1:0][DW-1:0] dvd_r, dvd_nxt;
  logic [LANES-1:0][VW-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][VW-1:0] d_r;
  logic [SBW-1:0]           sb_r;

  always_comb begin
    logic [VW:0] t;
    logic        ge;
    for (int l = 0; l < LANES; l++) begin
      t  = {rem_i[l], dvd_i[l][DW-1]};
      ge = t >= {1'b0, d_i[l]};
      rem_nxt[l] = ge ? VW'(t - {1'b0, d_i[l]}) : VW'(t);
      dvd_nxt[l] = {dvd_i[l][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      d_r   <= d_i;
      sb_r  <= sb_i;
    end
  end

  assign v_o   = v_r;
  assign dvd_o = dvd_r;
  assign rem_o = rem_r;
  assign d_o   = d_r;
  assign sb_o  = sb_r;

endmodule

@@ rtl/plsi_div_chain.sv @@
// Row of division cells that yields one quotient bit per cell.
module plsi_div_chain #(
  parameter int DW    = 26,
  parameter int VW    = 10,
  parameter int LANES = 3,
  parameter int SBW   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic [LANES-1:0][DW-1:0]   dvd_i,
  input  logic [LANES-1:0][VW-1:0]   d_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       v_o,
  output logic [LANES-1:0][DW-1:0]   quo_o,
  output logic [LANES-1:0][VW-1:0]   rem_o,
  output logic [SBW-1:0]             sb_o
);

  logic                     v_s   [0:DW];
  logic [LANES-1:0][DW-1:0] dvd_s [0:DW];
  logic [LANES-1:0][VW-1:0] rem_s [0:DW];
  logic [LANES-1:0][VW-1:0] d_s   [0:DW];
  logic [SBW-1:0]           sb_s  [0:DW];

  assign v_s[0]   = v_i;
  assign dvd_s[0] = dvd_i;
  assign rem_s[0] = '0;
  assign d_s[0]   = d_i;
  assign sb_s[0]  = sb_i;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    plsi_div_cell #(
      .DW(DW), .VW(VW), .LANES(LANES), .SBW(SBW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v_s[k]),
      .dvd_i (dvd_s[k]),
      .rem_i (rem_s[k]),
      .d_i   (d_s[k]),
      .sb_i  (sb_s[k]),
      .v_o   (v_s[k+1]),
      .dvd_o (dvd_s[k+1]),
      .rem_o (rem_s[k+1]),
      .d_o   (d_s[k+1]),
      .sb_o  (sb_s[k+1])
    );
  end

  assign v_o   = v_s[DW];
  assign quo_o = dvd_s[DW];
  assign rem_o = rem_s[DW];
  assign sb_o  = sb_s[DW];

endmodule

@@ rtl/plsi_out_buf.sv @@
// Two-entry result buffer that decouples the pipeline from a stalling receiver.
module plsi_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  plsi_pkg::out_beat_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output plsi_pkg::out_beat_t out_data
);

  plsi_pkg::out_beat_t mem_r [0:1];
  logic                wr_r, wr_nxt;
  logic                rd_r, rd_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = mem_r[rd_r];
  assign full      = cnt_r == 2'd2;

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full buffer");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !out_stall) |=> (cnt_r == 2'd1)) else $error("full buffer did not drain");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1 && push && out_stall) |=> full) else $error("buffer lost a beat");
`endif

endmodule

@@ rtl/periodic_lattice_site_index_top.sv @@
// Top level of the periodic lattice site index converter.
// The input channel (in_valid, in_stall, in_data) takes one beat per cycle:
// kind 0 wraps the three signed coordinates into the box and returns the
// linear site index; kind 1 splits site_in back into box coordinates.
// Every beat yields exactly one result beat on out_valid, out_stall, out_data,
// in the order of acceptance, with a fault code for bad fcc parity or an
// index outside the box.
// Throughput is one beat per cycle while the pipeline does not hold. From
// acceptance to out_valid a beat passes the input register, two rows of
// restoring division cells (one row of 26 cells for the coordinate reduction
// and the first index split, one row of 2*clog2(MAX_SIDE+1) cells for the
// second split), the multiply and sum stages and the result buffer.
// The configuration registers must be written over the APB-style port only
// while no beat is in flight; the block does not enforce this. Reset returns
// simple cubic mode, all sides 16 and an empty pipeline; no clearing is needed.
// When the receiver stalls, results collect in a two-entry buffer; once it is
// full the whole pipeline holds and in_stall rises until a result is taken.
module periodic_lattice_site_index_top #(
  parameter int MAX_SIDE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plsi_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plsi_pkg::out_beat_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int VW   = SW + 1;
  localparam int DW1  = (plsi_pkg::SITE_BITS > plsi_pkg::COORD_BITS) ?
                        plsi_pkg::SITE_BITS : plsi_pkg::COORD_BITS;
  localparam int QW   = 2 * SW;
  localparam int LW   = 3 * SW + 2;
  localparam int SB1  = 5 + plsi_pkg::SITE_BITS;
  localparam int SB2  = SB1 + 3 * VW;
  localparam int SUMW = 3 * SW + 1;
  localparam int CMPW = plsi_pkg::SITE_BITS + LW;

  // Configuration registers and derived box constants.
  logic          mode_r;
  logic [8:0]    side_a_r, side_b_r, side_c_r;
  logic [SW-1:0] na_r, nb_r, nc_r;
  logic [2*SW-1:0] nab_r;
  logic [LW-1:0]   limit_r;
  logic          wr_en;

  function automatic logic [SW-1:0] eff_side(input logic [8:0] s);
    logic [SW-1:0] e;
    if (s == 9'd0) begin
      e = SW'(1);
    end else if (32'(s) > 32'(MAX_SIDE)) begin
      e = SW'(MAX_SIDE);
    end else begin
      e = SW'(s);
    end
    return e;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      side_a_r <= 9'd16;
      side_b_r <= 9'd16;
      side_c_r <= 9'd16;
    end else if (wr_en) begin
      case (paddr[3:2])
        plsi_pkg::REG_MODE:   mode_r   <= pwdata[0];
        plsi_pkg::REG_SIDE_A: side_a_r <= pwdata[8:0];
        plsi_pkg::REG_SIDE_B: side_b_r <= pwdata[8:0];
        plsi_pkg::REG_SIDE_C: side_c_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      plsi_pkg::REG_MODE:   prdata = 32'(mode_r);
      plsi_pkg::REG_SIDE_A: prdata = 32'(side_a_r);
      plsi_pkg::REG_SIDE_B: prdata = 32'(side_b_r);
      plsi_pkg::REG_SIDE_C: prdata = 32'(side_c_r);
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    na_r    <= eff_side(side_a_r);
    nb_r    <= eff_side(side_b_r);
    nc_r    <= eff_side(side_c_r);
    nab_r   <= (2*SW)'(na_r * nb_r);
    limit_r <= mode_r ? (LW'(nab_r * nc_r) << 2) : LW'(nab_r * nc_r);
  end

  // Input register.
  logic               adv;
  logic               buf_full;
  logic               i_v_r;
  plsi_pkg::in_beat_t i_r;

  assign adv      = !buf_full;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (adv) begin
      i_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_r <= in_data;
    end
  end

  // Operands for the first division row.
  logic [2:0][DW1-1:0] c1_dvd;
  logic [2:0][VW-1:0]  c1_d;
  logic [SB1-1:0]      c1_sb;
  logic [2:0]          neg;

  always_comb begin
    logic [VW-1:0] ma, mb, mc;
    ma = mode_r ? {na_r, 1'b0} : VW'(na_r);
    mb = mode_r ? {nb_r, 1'b0} : VW'(nb_r);
    mc = mode_r ? {nc_r, 1'b0} : VW'(nc_r);
    if (!i_r.kind) begin
      neg = {i_r.z_coord[plsi_pkg::COORD_BITS-1], i_r.y_coord[plsi_pkg::COORD_BITS-1],
             i_r.x_coord[plsi_pkg::COORD_BITS-1]};
      c1_dvd[0] = DW1'(neg[0] ? -i_r.x_coord : i_r.x_coord);
      c1_dvd[1] = DW1'(neg[1] ? -i_r.y_coord : i_r.y_coord);
      c1_dvd[2] = DW1'(neg[2] ? -i_r.z_coord : i_r.z_coord);
      c1_d = {mc, mb, ma};
    end else begin
      neg = 3'b000;
      c1_dvd[0] = mode_r ? DW1'(i_r.site_in[plsi_pkg::SITE_BITS-1:2]) : DW1'(i_r.site_in);
      c1_dvd[1] = '0;
      c1_dvd[2] = '0;
      c1_d = {VW'(1), VW'(1), VW'(na_r)};
    end
    c1_sb = {i_r.kind, mode_r, neg, i_r.site_in};
  end

  logic                c1_v;
  logic [2:0][DW1-1:0] c1_quo;
  logic [2:0][VW-1:0]  c1_rem;
  logic [SB1-1:0]      c1_sbo;

  plsi_div_chain #(.DW(DW1), .VW(VW), .LANES(3), .SBW(SB1)) u_chain1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .v_i   (i_v_r),
    .dvd_i (c1_dvd),
    .d_i   (c1_d),
    .sb_i  (c1_sb),
    .v_o   (c1_v),
    .quo_o (c1_quo),
    .rem_o (c1_rem),
    .sb_o  (c1_sbo)
  );

  // Floor correction of negative coordinates, then the second split.
  logic [2:0][VW-1:0] radj;
  logic [0:0][QW-1:0] c2_dvd;
  logic [0:0][VW-1:0] c2_d;
  logic [SB2-1:0]     c2_sb;

  always_comb begin
    logic [2:0][VW-1:0] m;
    logic [2:0]         ng;
    logic               fc;
    fc = c1_sbo[SB1-2];
    ng = c1_sbo[SB1-3 -: 3];
    m[0] = fc ? {na_r, 1'b0} : VW'(na_r);
    m[1] = fc ? {nb_r, 1'b0} : VW'(nb_r);
    m[2] = fc ? {nc_r, 1'b0} : VW'(nc_r);
    for (int l = 0; l < 3; l++) begin
      radj[l] = (ng[l] && c1_rem[l] != '0) ? VW'(m[l] - c1_rem[l]) : c1_rem[l];
    end
    c2_dvd[0] = c1_sbo[SB1-1] ? QW'(c1_quo[0]) : '0;
    c2_d[0]   = VW'(nb_r);
    c2_sb     = {c1_sbo, radj};
  end

  logic               c2_v;
  logic [0:0][QW-1:0] c2_quo;
  logic [0:0][VW-1:0] c2_rem;
  logic [SB2-1:0]     c2_sbo;

  plsi_div_chain #(.DW(QW), .VW(VW), .LANES(1), .SBW(SB2)) u_chain2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .v_i   (c1_v),
    .dvd_i (c2_dvd),
    .d_i   (c2_d),
    .sb_i  (c2_sb),
    .v_o   (c2_v),
    .quo_o (c2_quo),
    .rem_o (c2_rem),
    .sb_o  (c2_sbo)
  );

  // Multiply stage.
  logic                         m_v_r;
  logic                         m_kind_r, m_fcc_r, m_range_r;
  logic [2:0]                   m_pat_r;
  logic [SW-1:0]                m_xh_r;
  logic [2*SW-1:0]              m_pb_r;
  logic [3*SW-1:0]              m_pc_r;
  logic [plsi_pkg::OUT_BITS-1:0] m_xo_r, m_yo_r, m_zo_r;

  logic [VW-1:0]  ra, rb, rc;
  logic           s2_kind, s2_fcc;
  logic [plsi_pkg::SITE_BITS-1:0] s2_n;
  logic [SW-1:0]  xh, yh, zh;
  logic [SW-1:0]  ka, kb, kc;
  logic [2:0]     par;

  assign ra      = c2_sbo[VW-1:0];
  assign rb      = c2_sbo[2*VW-1:VW];
  assign rc      = c2_sbo[3*VW-1:2*VW];
  assign s2_n    = c2_sbo[3*VW +: plsi_pkg::SITE_BITS];
  assign s2_fcc  = c2_sbo[SB2-2];
  assign s2_kind = c2_sbo[SB2-1];
  assign xh      = s2_fcc ? ra[VW-1:1] : ra[SW-1:0];
  assign yh      = s2_fcc ? rb[VW-1:1] : rb[SW-1:0];
  assign zh      = s2_fcc ? rc[VW-1:1] : rc[SW-1:0];
  assign ka      = ra[SW-1:0];
  assign kb      = c2_rem[0][SW-1:0];
  assign kc      = c2_quo[0][SW-1:0];
  assign par     = s2_fcc ? plsi_pkg::fcc_parity(s2_n[1:0]) : 3'b000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_kind_r  <= s2_kind;
      m_fcc_r   <= s2_fcc;
      m_pat_r   <= {rc[0], rb[0], ra[0]};
      m_xh_r    <= xh;
      m_pb_r    <= (2*SW)'(yh * na_r);
      m_pc_r    <= (3*SW)'(zh * nab_r);
      m_range_r <= CMPW'(s2_n) >= CMPW'(limit_r);
      m_xo_r    <= s2_fcc ? plsi_pkg::OUT_BITS'({ka, par[2]}) : plsi_pkg::OUT_BITS'(ka);
      m_yo_r    <= s2_fcc ? plsi_pkg::OUT_BITS'({kb, par[1]}) : plsi_pkg::OUT_BITS'(kb);
      m_zo_r    <= s2_fcc ? plsi_pkg::OUT_BITS'({kc, par[0]}) : plsi_pkg::OUT_BITS'(kc);
    end
  end

  // Sum stage and result assembly.
  logic                s_v_r;
  plsi_pkg::out_beat_t s_r, s_nxt;

  always_comb begin
    logic [SUMW-1:0] sum;
    sum = SUMW'(m_xh_r) + SUMW'(m_pb_r) + SUMW'(m_pc_r);
    s_nxt = '0;
    if (!m_kind_r) begin
      if (!m_fcc_r) begin
        s_nxt.site_out = plsi_pkg::SITE_BITS'(sum);
      end else if (plsi_pkg::fcc_valid(m_pat_r)) begin
        s_nxt.site_out = plsi_pkg::SITE_BITS'({sum, plsi_pkg::fcc_offset(m_pat_r)});
      end else begin
        s_nxt.fault = plsi_pkg::FAULT_PARITY;
      end
    end else if (m_range_r) begin
      s_nxt.fault = plsi_pkg::FAULT_RANGE;
    end else begin
      s_nxt.x_out = m_xo_r;
      s_nxt.y_out = m_yo_r;
      s_nxt.z_out = m_zo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (adv) begin
      s_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_nxt;
    end
  end

  plsi_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s_v_r && adv),
    .push_data (s_r),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_stall_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no result waiting");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (s_v_r && adv) |=> out_valid) else $error("finished beat not presented");
  a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fault != plsi_pkg::FAULT_NONE) |->
    (out_data.site_out == '0 && out_data.x_out == '0 && out_data.y_out == '0 &&
     out_data.z_out == '0)) else $error("fault beat carries data");
`endif

endmodule
